>>> rtl/core/cmar_pkg.sv
// Shared types and constants for the centered moving average block.
// Depends on nothing; cmar_div, the top level and cmar_checker import it.
`timescale 1ns / 1ps

package cmar_pkg;

    // Fixed widths of the sample field and of the half window setting.
    localparam int SAMPLE_WIDTH = 24;
    localparam int HW_WIDTH     = 5;

    // Register port geometry: one 32-bit register, word addressed by paddr[2].
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_HALF_WINDOW = 1'b0;

    // Reset value of the half window register.
    localparam logic [HW_WIDTH-1:0] HALF_WINDOW_RESET = HW_WIDTH'(1);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           seq_end;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] mean;
        logic                           final_res;
    } t_out_item;

    // Status that the divider reports to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SUM,
        S_FIN,
        S_DIVS,
        S_DIVW,
        S_OUT
    } t_state;

endpackage

>>> rtl/core/cmar_store.sv
// Sample ring memory: one write port and one read port, registered read data.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module cmar_store #(
    parameter int DEPTH  = 33,
    parameter int DATA_W = 24
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/cmar_div.sv
// Signed restoring divider by a small unsigned divisor, one quotient bit a cycle.
// Depends on cmar_pkg for the status struct.
`timescale 1ns / 1ps

module cmar_div
    import cmar_pkg::*;
#(
    parameter int DVD_W = 30,
    parameter int DVS_W = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]        i_divisor,
    output logic signed [DVD_W-1:0] o_quot,
    output t_div_status             o_status
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;
    logic             r_neg;

    logic [DVS_W:0]   shifted;
    logic             q_bit;
    logic [DVS_W:0]   diff;

    // One restoring step: bring down the next dividend bit and try to subtract.
    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        q_bit   = (shifted >= {1'b0, r_dvs});
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend magnitude shifts out while quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DVD_W-1];
            r_quo <= i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], q_bit};
            r_rem <= q_bit ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    // Truncation toward zero: divide the magnitude, then restore the sign.
    assign o_quot          = r_neg ? -$signed(r_quo) : $signed(r_quo);
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;

endmodule

>>> rtl/core/centered_moving_average_replicate_unit.sv
// Top level of the centered moving average with replicated edges.
// Depends on cmar_pkg, cmar_store and cmar_div.
`timescale 1ns / 1ps

// Usage:
// Samples arrive on the request channel (i_in_valid, i_in_data, o_in_stall); the
// last sample of a sequence carries seq_end. Means leave on the result channel
// (o_out_valid, o_out_data, i_out_stall). A request is taken at a clock edge with
// valid high and stall low. Mean i appears once sample i+W has been taken; the
// request that ends a sequence flushes all means still owed, the final one marked
// with final_res. Samples that complete no window give no result.
// Each mean reads its 2W+1 window samples from the ring memory, one per cycle,
// then runs the sum through the bit-serial divider, one quotient bit per cycle.
// The sum is SUM_W bits wide (SUM_W = 30 at the default size). A sample that
// completes no window goes from S_IDLE through S_PREP back to S_IDLE; one that
// gives a mean goes on through S_SUM, S_FIN, S_DIVS, S_DIVW and S_OUT, and each
// further mean of a flush repeats from S_SUM. The block works on one request at
// a time; the result register lets it take the next sample while the last mean
// still waits at a stalled receiver, and the mean unit waits when that register
// is still full.
// Synchronous reset empties the result register, closes any sequence and sets
// half_window to 1. Writing half_window abandons an open sequence.

module centered_moving_average_replicate_unit
    import cmar_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Sample requests.
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    // Mean results.
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall,
    // Register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int AGE_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int W_W   = $clog2(MAX_HALF_WINDOW + 1);
    localparam int SUM_W = SAMPLE_WIDTH + $clog2(DEPTH);

    t_state                         r_state;
    t_state                         n_state;
    logic [HW_WIDTH-1:0]            r_hw;
    logic                           r_in_seq;
    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               n_count;
    logic [AGE_W-1:0]               r_wp;
    logic [AGE_W-1:0]               n_wp;
    logic signed [SAMPLE_WIDTH-1:0] r_first;
    logic                           r_last;
    logic [W_W-1:0]                 r_center;
    logic [AGE_W-1:0]               r_j;
    logic signed [SUM_W-1:0]        r_sum;
    logic                           r_pend_valid;
    logic                           r_pend_first;
    logic                           r_out_valid;
    t_out_item                      r_out;

    logic                           in_acc;
    logic                           cfg_wr;
    logic [W_W-1:0]                 w_eff;
    logic [CNT_W-1:0]               pos;
    logic                           prep_emit;
    logic                           last_term;
    logic [AGE_W:0]                 age_s;
    logic [AGE_W-1:0]               age;
    logic [AGE_W:0]                 addr_s;
    logic [AGE_W-1:0]               rd_addr;
    logic                           use_first;
    logic [SAMPLE_WIDTH-1:0]        rd_data;
    logic signed [SAMPLE_WIDTH-1:0] term;
    logic signed [SUM_W-1:0]        quot;
    t_div_status                    div_st;
    logic [CNT_W-1:0]               divisor;
    logic                           more_means;

    // Control outputs of the state machine.
    logic                           ctl_stall;
    logic                           ctl_rd_en;
    logic                           ctl_div_start;
    logic                           ctl_out_load;

    assign in_acc = i_in_valid && !o_in_stall;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HALF_WINDOW);

    // Register read-back and the always-ready access phase.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HALF_WINDOW) ? APB_DATA_W'(r_hw) : '0;

    // Effective half window: larger settings saturate at the store's reach.
    assign w_eff = (int'(r_hw) > MAX_HALF_WINDOW) ? W_W'(MAX_HALF_WINDOW) : W_W'(r_hw);
    assign divisor = CNT_W'({w_eff, 1'b1});

    // Ring pointer and saturating sample count for the incoming sample.
    always_comb begin
        n_wp = (r_wp == AGE_W'(DEPTH - 1)) ? '0 : r_wp + AGE_W'(1);
        if (!r_in_seq) begin
            n_count = CNT_W'(1);
        end else if (r_count == CNT_W'(DEPTH)) begin
            n_count = r_count;
        end else begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // Position of the newest sample; a mean is owed once W samples follow it.
    assign pos       = r_count - CNT_W'(1);
    assign prep_emit = r_last || (pos >= CNT_W'(w_eff));

    // Age of window term j, clipped at the newest sample.
    always_comb begin
        age_s     = (AGE_W+1)'(r_center) + (AGE_W+1)'(w_eff) - (AGE_W+1)'(r_j);
        age       = age_s[AGE_W] ? '0 : age_s[AGE_W-1:0];
        use_first = (CNT_W'(age) >= r_count);
        addr_s    = {1'b0, r_wp} + (AGE_W+1)'(DEPTH) - {1'b0, age};
        rd_addr   = (addr_s >= (AGE_W+1)'(DEPTH)) ? AGE_W'(addr_s - (AGE_W+1)'(DEPTH))
                                                  : addr_s[AGE_W-1:0];
        last_term = (r_j == (AGE_W'(w_eff) << 1));
    end

    assign term       = r_pend_first ? r_first : $signed(rd_data);
    assign more_means = r_last && (r_center != '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = prep_emit ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                if (last_term) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_DIVS;
            end
            S_DIVS: begin
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (div_st.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = more_means ? S_SUM : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State machine outputs.
    always_comb begin
        ctl_stall     = 1'b1;
        ctl_rd_en     = 1'b0;
        ctl_div_start = 1'b0;
        ctl_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: ctl_stall = 1'b0;
            S_PREP: ctl_stall = 1'b1;
            S_SUM:  ctl_rd_en = 1'b1;
            S_FIN:  ctl_stall = 1'b1;
            S_DIVS: ctl_div_start = 1'b1;
            S_DIVW: ctl_stall = 1'b1;
            S_OUT:  ctl_out_load = !r_out_valid || !i_out_stall;
            default: ctl_stall = 1'b1;
        endcase
    end

    assign o_in_stall = ctl_stall;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hw         <= HALF_WINDOW_RESET;
            r_in_seq     <= 1'b0;
            r_count      <= '0;
            r_wp         <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= ctl_rd_en;
            if (cfg_wr) begin
                r_hw     <= pwdata[HW_WIDTH-1:0];
                r_in_seq <= 1'b0;
                r_count  <= '0;
            end else if (in_acc) begin
                r_wp     <= n_wp;
                r_count  <= n_count;
                r_in_seq <= !i_in_data.seq_end;
            end else if (ctl_out_load && !more_means && r_last) begin
                // The flush is complete: the next sample opens a new sequence.
                r_count <= '0;
            end
            if (ctl_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sequence bookkeeping and window accumulation.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_last <= i_in_data.seq_end;
            if (!r_in_seq) begin
                r_first <= i_in_data.sample;
            end
        end
        if (r_state == S_PREP) begin
            if (r_last && (pos < CNT_W'(w_eff))) begin
                r_center <= W_W'(pos);
            end else begin
                r_center <= w_eff;
            end
        end else if (ctl_out_load && more_means) begin
            r_center <= r_center - W_W'(1);
        end
        if (r_state == S_PREP || ctl_out_load) begin
            r_j   <= '0;
            r_sum <= '0;
        end else begin
            if (ctl_rd_en) begin
                r_j <= r_j + AGE_W'(1);
            end
            if (r_pend_valid) begin
                r_sum <= r_sum + SUM_W'(term);
            end
        end
        r_pend_first <= use_first;
        if (ctl_out_load) begin
            r_out.mean      <= quot[SAMPLE_WIDTH-1:0];
            r_out.final_res <= r_last && (r_center == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The sample is written when taken in S_IDLE; window reads run only in S_SUM,
    // after S_PREP, so a read never meets the write of the same entry.
    cmar_store #(
        .DEPTH  (DEPTH),
        .DATA_W (SAMPLE_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (n_wp),
        .i_wr_data (i_in_data.sample),
        .i_rd_en   (ctl_rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cmar_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctl_div_start),
        .i_dividend (r_sum),
        .i_divisor  (divisor),
        .o_quot     (quot),
        .o_status   (div_st)
    );

endmodule

>>> rtl/core/cmar_checker.sv
// Port-level checks for the centered moving average top level, and their bind.
// Depends on cmar_pkg and centered_moving_average_replicate_unit.
`timescale 1ns / 1ps

module cmar_checker
    import cmar_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    // Reset leaves the block ready for a request with no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("result pending or request stalled after reset");

    // A taken sample always occupies the sequencer, which stalls the next request.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken again in the cycle after a request");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result changed while stalled");

endmodule

bind centered_moving_average_replicate_unit cmar_checker u_cmar_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
